/* hw/rtl/gdlos_pkg.sv */
// Shared constants, types and helpers of the grid line-of-sight block.
`default_nettype none
package gdlos_pkg;

  localparam int MAX_MAP_WIDTH  = 64;
  localparam int MAX_MAP_HEIGHT = 64;
  localparam int MAX_TILE_SIZE  = 64;
  localparam int MAP_DEPTH      = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
  localparam int MAP_AW         = $clog2(MAP_DEPTH);
  localparam int COL_AW         = $clog2(MAX_MAP_WIDTH);
  localparam int ROW_AW         = $clog2(MAX_MAP_HEIGHT);

  localparam int PIX_W  = 12;  // pixel coordinate
  localparam int CFG_W  = 7;   // configuration register
  localparam int CELL_W = 14;  // signed tile column or row during the walk
  localparam int FIX_W  = 32;  // Q16.16 distance
  localparam int RAD_W  = 64;  // square root radicand
  localparam int CNT_W  = 5;

  localparam int SQRT_ITERS = 32;
  localparam int DIV_ITERS  = 32;

  localparam logic [FIX_W-1:0] SAT32 = '1;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TILE_SIZE  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PREP, ST_SQ, ST_SQRT, ST_DLOAD, ST_DIV, ST_DSAVE,
    ST_WINIT, ST_STEP, ST_TEST, ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_FLAG, OP_LOAD, OP_PREP, OP_SQ_INIT, OP_SQRT,
    OP_DIV_INIT, OP_DIV, OP_DIV_SAVE, OP_WALK_INIT, OP_STEP
  } dp_op_t;

  typedef enum logic [1:0] {
    DIV_STEP_X, DIV_STEP_Y, DIV_ORG_X, DIV_ORG_Y
  } div_sel_t;

  typedef struct packed {
    dp_op_t              op;
    div_sel_t            sel;
    logic [MAP_AW-1:0]   clr_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic cell_wall;
  } dp_stat_t;

  // Register write value with saturation at the largest legal setting.
  function automatic logic [CFG_W-1:0] cfg_sat(input logic [CFG_W-1:0] v,
                                               input int unsigned lim);
    logic [CFG_W-1:0] r;
    r = (32'(v) > lim) ? CFG_W'(lim) : v;
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/grid_dda_line_of_sight_core.sv */
// Line-of-sight core: after reset a clearing pass opens every tile of the wall map,
// during which no input beat is taken (register writes still are). A wall-flag beat
// is taken and gives no result. A cast runs a bit-pair square root for the ray length,
// then four passes of a one-bit-per-cycle divider (two axis steps and the tile position
// of the origin), then a step state and a test state per pixel cell walked, set by the
// registered read of the wall map. One cast is in flight at a time; a finished result
// waits in an output register while the next beat is taken.
`default_nettype none
module grid_dda_line_of_sight_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [11:0] tile_index, [12] wall_flag, [24:13] origin_x, [36:25] origin_y,
  // [48:37] target_x, [60:49] target_y, [63:61] zero
  input  wire logic [63:0] in_tdata,
  // [0] action
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] sight_clear, [7:1] zero
  output logic [7:0]       out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CFG_W = gdlos_pkg::CFG_W;

  logic [CFG_W-1:0] width_r, height_r, tile_r;
  logic [1:0]       reg_idx;
  logic             cfg_wr;
  logic             out_clear;
  gdlos_pkg::dp_cmd_t  cmd;
  gdlos_pkg::dp_stat_t stat;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(64);
      height_r <= CFG_W'(64);
      tile_r   <= CFG_W'(32);
    end else if (cfg_wr) begin
      if (reg_idx == gdlos_pkg::REG_MAP_WIDTH) begin
        width_r <= gdlos_pkg::cfg_sat(cfg_pwdata[CFG_W-1:0], gdlos_pkg::MAX_MAP_WIDTH);
      end
      if (reg_idx == gdlos_pkg::REG_MAP_HEIGHT) begin
        height_r <= gdlos_pkg::cfg_sat(cfg_pwdata[CFG_W-1:0], gdlos_pkg::MAX_MAP_HEIGHT);
      end
      if (reg_idx == gdlos_pkg::REG_TILE_SIZE) begin
        tile_r <= gdlos_pkg::cfg_sat(cfg_pwdata[CFG_W-1:0], gdlos_pkg::MAX_TILE_SIZE);
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      gdlos_pkg::REG_MAP_WIDTH:  cfg_prdata = 32'(width_r);
      gdlos_pkg::REG_MAP_HEIGHT: cfg_prdata = 32'(height_r);
      gdlos_pkg::REG_TILE_SIZE:  cfg_prdata = 32'(tile_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  gdlos_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_clear  (out_clear),
    .cmd        (cmd),
    .stat       (stat)
  );

  gdlos_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .tile_index (in_tdata[11:0]),
    .wall_flag  (in_tdata[12]),
    .origin_x   (in_tdata[24:13]),
    .origin_y   (in_tdata[36:25]),
    .target_x   (in_tdata[48:37]),
    .target_y   (in_tdata[60:49]),
    .map_width  (width_r),
    .map_height (height_r),
    .tile_size  (tile_r),
    .stat       (stat)
  );

  assign out_tdata = {7'd0, out_clear};

endmodule
`default_nettype wire

/* hw/rtl/gdlos_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gdlos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* hw/rtl/gdlos_ctrl.sv */
// Controller state machine: sequences clearing, root, divisions and the cell walk.
`default_nettype none
module gdlos_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_action,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic                    out_clear,
  output gdlos_pkg::dp_cmd_t      cmd,
  input  wire gdlos_pkg::dp_stat_t stat
);

  localparam int CNT_W = gdlos_pkg::CNT_W;

  gdlos_pkg::ctrl_state_t state_r, state_nxt;
  gdlos_pkg::div_sel_t    sel_r, sel_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [gdlos_pkg::MAP_AW-1:0] clr_r, clr_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_clear_r, out_clear_nxt;
  logic res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gdlos_pkg::ST_CLEAR;
      sel_r       <= gdlos_pkg::DIV_STEP_X;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_clear_r <= out_clear_nxt;
    res_r       <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    res_nxt       = res_r;
    out_clear_nxt = out_clear_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    in_tready     = 1'b0;
    cmd.op        = gdlos_pkg::OP_NONE;
    cmd.sel       = sel_r;
    cmd.clr_addr  = clr_r;
    unique case (state_r)
      gdlos_pkg::ST_CLEAR: begin
        cmd.op  = gdlos_pkg::OP_CLEAR;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == gdlos_pkg::MAP_DEPTH - 1) begin
          state_nxt = gdlos_pkg::ST_IDLE;
        end
      end
      gdlos_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_action) begin
            cmd.op    = gdlos_pkg::OP_LOAD;
            state_nxt = gdlos_pkg::ST_PREP;
          end else begin
            cmd.op = gdlos_pkg::OP_FLAG;
          end
        end
      end
      gdlos_pkg::ST_PREP: begin
        cmd.op    = gdlos_pkg::OP_PREP;
        state_nxt = gdlos_pkg::ST_SQ;
      end
      gdlos_pkg::ST_SQ: begin
        cmd.op    = gdlos_pkg::OP_SQ_INIT;
        cnt_nxt   = '0;
        state_nxt = gdlos_pkg::ST_SQRT;
      end
      gdlos_pkg::ST_SQRT: begin
        cmd.op  = gdlos_pkg::OP_SQRT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(gdlos_pkg::SQRT_ITERS - 1)) begin
          sel_nxt   = gdlos_pkg::DIV_STEP_X;
          state_nxt = gdlos_pkg::ST_DLOAD;
        end
      end
      gdlos_pkg::ST_DLOAD: begin
        cmd.op    = gdlos_pkg::OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = gdlos_pkg::ST_DIV;
      end
      gdlos_pkg::ST_DIV: begin
        cmd.op  = gdlos_pkg::OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(gdlos_pkg::DIV_ITERS - 1)) begin
          state_nxt = gdlos_pkg::ST_DSAVE;
        end
      end
      gdlos_pkg::ST_DSAVE: begin
        cmd.op = gdlos_pkg::OP_DIV_SAVE;
        if (sel_r == gdlos_pkg::DIV_ORG_Y) begin
          state_nxt = gdlos_pkg::ST_WINIT;
        end else begin
          sel_nxt   = gdlos_pkg::div_sel_t'(sel_r + 2'd1);
          state_nxt = gdlos_pkg::ST_DLOAD;
        end
      end
      gdlos_pkg::ST_WINIT: begin
        cmd.op    = gdlos_pkg::OP_WALK_INIT;
        state_nxt = gdlos_pkg::ST_STEP;
      end
      gdlos_pkg::ST_STEP: begin
        if (stat.walk_done) begin
          res_nxt   = 1'b1;
          state_nxt = gdlos_pkg::ST_DONE;
        end else begin
          cmd.op    = gdlos_pkg::OP_STEP;
          state_nxt = gdlos_pkg::ST_TEST;
        end
      end
      gdlos_pkg::ST_TEST: begin
        if (stat.cell_wall) begin
          res_nxt   = 1'b0;
          state_nxt = gdlos_pkg::ST_DONE;
        end else begin
          state_nxt = gdlos_pkg::ST_STEP;
        end
      end
      gdlos_pkg::ST_DONE: begin
        // The result register may still hold the previous beat.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_clear_nxt = res_r;
          state_nxt     = gdlos_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gdlos_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_clear  = out_clear_r;

endmodule
`default_nettype wire

/* hw/rtl/gdlos_dp.sv */
// Datapath: wall map, iterative root and divider, and the per-cell walk registers.
`default_nettype none
module gdlos_dp (
  input  wire logic                          clk,
  input  wire gdlos_pkg::dp_cmd_t            cmd,
  input  wire logic [gdlos_pkg::PIX_W-1:0]   tile_index,
  input  wire logic                          wall_flag,
  input  wire logic [gdlos_pkg::PIX_W-1:0]   origin_x,
  input  wire logic [gdlos_pkg::PIX_W-1:0]   origin_y,
  input  wire logic [gdlos_pkg::PIX_W-1:0]   target_x,
  input  wire logic [gdlos_pkg::PIX_W-1:0]   target_y,
  input  wire logic [gdlos_pkg::CFG_W-1:0]   map_width,
  input  wire logic [gdlos_pkg::CFG_W-1:0]   map_height,
  input  wire logic [gdlos_pkg::CFG_W-1:0]   tile_size,
  output gdlos_pkg::dp_stat_t                stat
);

  localparam int PIX_W  = gdlos_pkg::PIX_W;
  localparam int FIX_W  = gdlos_pkg::FIX_W;
  localparam int RAD_W  = gdlos_pkg::RAD_W;
  localparam int CELL_W = gdlos_pkg::CELL_W;
  localparam int CFG_W  = gdlos_pkg::CFG_W;
  localparam int MAP_AW = gdlos_pkg::MAP_AW;

  logic [PIX_W-1:0]  ox_r, oy_r, tx_r, ty_r;
  logic [PIX_W-1:0]  adx_r, ady_r;
  logic              negx_r, negy_r;
  logic [RAD_W-1:0]  v_r, res_r, bit_r;
  logic [FIX_W-1:0]  divd_r;
  logic [PIX_W-1:0]  drem_r, dvs_r;
  logic [FIX_W-1:0]  stepx_r, stepy_r, lenx_r, leny_r, dist_r;
  logic signed [CELL_W-1:0] col_r, row_r;
  logic [CFG_W-1:0]  remx_r, remy_r;
  logic              inb_r;

  logic [FIX_W-1:0]  dmax;
  logic [PIX_W:0]    dx, dy;
  logic [2*PIX_W:0]  sq;
  logic [RAD_W-1:0]  sq_try;
  logic              sq_ge;
  logic [PIX_W:0]    trial;
  logic              div_ge;
  logic              go_x;
  logic [FIX_W:0]    len_sum;
  logic [FIX_W-1:0]  len_new;
  logic signed [CELL_W-1:0] col_nxt, row_nxt;
  logic [CFG_W-1:0]  remx_nxt, remy_nxt;
  logic              inb_nxt;
  logic              ram_we, ram_wd, ram_rd;
  logic [MAP_AW-1:0] ram_wa, ram_ra;

  assign dmax = res_r[FIX_W-1:0];

  // Floor-division step of a cell coordinate: column and remainder in the tile.
  function automatic logic [CFG_W+CELL_W-1:0] cell_move(
      input logic signed [CELL_W-1:0] c, input logic [CFG_W-1:0] r,
      input logic neg, input logic [CFG_W-1:0] t);
    logic signed [CELL_W-1:0] cn;
    logic [CFG_W-1:0] rn;
    if (neg) begin
      if (r == '0) begin
        cn = c - CELL_W'(1);
        rn = t - 1'b1;
      end else begin
        cn = c;
        rn = r - 1'b1;
      end
    end else begin
      if (r + 1'b1 == t) begin
        cn = c + CELL_W'(1);
        rn = '0;
      end else begin
        cn = c;
        rn = r + 1'b1;
      end
    end
    return {cn, rn};
  endfunction

  always_comb begin
    dx     = {1'b0, tx_r} - {1'b0, ox_r};
    dy     = {1'b0, ty_r} - {1'b0, oy_r};
    sq     = (2*PIX_W+1)'(adx_r * adx_r) + (2*PIX_W+1)'(ady_r * ady_r);
    sq_try = res_r + bit_r;
    sq_ge  = v_r >= sq_try;
    trial  = {drem_r, divd_r[FIX_W-1]};
    div_ge = trial >= {1'b0, dvs_r};
    go_x   = lenx_r < leny_r;
    len_sum = go_x ? ({1'b0, lenx_r} + {1'b0, stepx_r}) : ({1'b0, leny_r} + {1'b0, stepy_r});
    len_new = len_sum[FIX_W] ? gdlos_pkg::SAT32 : len_sum[FIX_W-1:0];
    col_nxt  = col_r;
    remx_nxt = remx_r;
    row_nxt  = row_r;
    remy_nxt = remy_r;
    if (go_x) begin
      {col_nxt, remx_nxt} = cell_move(col_r, remx_r, negx_r, tile_size);
    end else begin
      {row_nxt, remy_nxt} = cell_move(row_r, remy_r, negy_r, tile_size);
    end
    inb_nxt = (tile_size != '0) && !col_nxt[CELL_W-1] && !row_nxt[CELL_W-1]
           && (col_nxt < $signed({{(CELL_W-CFG_W){1'b0}}, map_width}))
           && (row_nxt < $signed({{(CELL_W-CFG_W){1'b0}}, map_height}));
    ram_ra = MAP_AW'(32'(row_nxt[gdlos_pkg::ROW_AW-1:0]) * gdlos_pkg::MAX_MAP_WIDTH
                     + 32'(col_nxt[gdlos_pkg::COL_AW-1:0]));
    ram_we = 1'b0;
    ram_wa = cmd.clr_addr;
    ram_wd = 1'b0;
    if (cmd.op == gdlos_pkg::OP_CLEAR) begin
      ram_we = 1'b1;
    end else if (cmd.op == gdlos_pkg::OP_FLAG) begin
      ram_we = 32'(tile_index) < gdlos_pkg::MAP_DEPTH;
      ram_wa = MAP_AW'(tile_index);
      ram_wd = wall_flag;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gdlos_pkg::OP_LOAD: begin
        ox_r <= origin_x;
        oy_r <= origin_y;
        tx_r <= target_x;
        ty_r <= target_y;
      end
      gdlos_pkg::OP_PREP: begin
        negx_r <= dx[PIX_W];
        negy_r <= dy[PIX_W];
        adx_r  <= dx[PIX_W] ? PIX_W'(-dx) : dx[PIX_W-1:0];
        ady_r  <= dy[PIX_W] ? PIX_W'(-dy) : dy[PIX_W-1:0];
      end
      gdlos_pkg::OP_SQ_INIT: begin
        // Radicand is the squared length in Q32.32, so the root comes out in Q16.16.
        v_r   <= RAD_W'(sq) << 32;
        res_r <= '0;
        bit_r <= RAD_W'(1) << (RAD_W - 2);
      end
      gdlos_pkg::OP_SQRT: begin
        if (sq_ge) begin
          v_r   <= v_r - sq_try;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      gdlos_pkg::OP_DIV_INIT: begin
        drem_r <= '0;
        unique case (cmd.sel)
          gdlos_pkg::DIV_STEP_X: begin
            divd_r <= dmax;
            dvs_r  <= adx_r;
          end
          gdlos_pkg::DIV_STEP_Y: begin
            divd_r <= dmax;
            dvs_r  <= ady_r;
          end
          gdlos_pkg::DIV_ORG_X: begin
            divd_r <= FIX_W'(ox_r);
            dvs_r  <= PIX_W'(tile_size);
          end
          gdlos_pkg::DIV_ORG_Y: begin
            divd_r <= FIX_W'(oy_r);
            dvs_r  <= PIX_W'(tile_size);
          end
          default: divd_r <= dmax;
        endcase
      end
      gdlos_pkg::OP_DIV: begin
        drem_r <= div_ge ? PIX_W'(trial - {1'b0, dvs_r}) : trial[PIX_W-1:0];
        divd_r <= {divd_r[FIX_W-2:0], div_ge};
      end
      gdlos_pkg::OP_DIV_SAVE: begin
        unique case (cmd.sel)
          gdlos_pkg::DIV_STEP_X: stepx_r <= (adx_r == '0) ? gdlos_pkg::SAT32 : divd_r;
          gdlos_pkg::DIV_STEP_Y: stepy_r <= (ady_r == '0) ? gdlos_pkg::SAT32 : divd_r;
          gdlos_pkg::DIV_ORG_X: begin
            col_r  <= CELL_W'(divd_r[PIX_W-1:0]);
            remx_r <= drem_r[CFG_W-1:0];
          end
          gdlos_pkg::DIV_ORG_Y: begin
            row_r  <= CELL_W'(divd_r[PIX_W-1:0]);
            remy_r <= drem_r[CFG_W-1:0];
          end
          default: stepx_r <= divd_r;
        endcase
      end
      gdlos_pkg::OP_WALK_INIT: begin
        lenx_r <= negx_r ? '0 : stepx_r;
        leny_r <= negy_r ? '0 : stepy_r;
        dist_r <= '0;
      end
      gdlos_pkg::OP_STEP: begin
        if (go_x) begin
          dist_r <= lenx_r;
          lenx_r <= len_new;
        end else begin
          dist_r <= leny_r;
          leny_r <= len_new;
        end
        col_r  <= col_nxt;
        remx_r <= remx_nxt;
        row_r  <= row_nxt;
        remy_r <= remy_nxt;
        inb_r  <= inb_nxt;
      end
      default: begin
      end
    endcase
  end

  gdlos_ram #(
    .WIDTH (1),
    .DEPTH (gdlos_pkg::MAP_DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign stat.walk_done = !(dist_r < dmax);
  assign stat.cell_wall = inb_r & ram_rd;

endmodule
`default_nettype wire

/* hw/rtl/gdlos_checker.sv */
// Port-level checks of the line-of-sight core, bound to the top level.
`default_nettype none
module gdlos_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata
);

  // A result beat that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // The map is being cleared in the first cycle after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> !in_tready)
    else $error("input taken during clearing pass");

  // A cast keeps the block busy for the following cycle.
  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> !in_tready)
    else $error("input taken while a cast is running");

  // Padding bits of the result stay zero.
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

endmodule

bind grid_dda_line_of_sight_core gdlos_checker u_gdlos_checker (.*);
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench of the grid line-of-sight core: directed table, then random beats.
`default_nettype none
module tb_top;

  typedef enum bit {ACT_FLAG = 1'b0, ACT_CAST = 1'b1} action_t;

  typedef struct {
    action_t    act;
    bit [11:0]  tile;
    bit         flag;
    bit [11:0]  ox, oy, tx, ty;
    bit         typed;   // expected result written in the row
    bit         clear;
  } los_row_t;

  localparam int WATCHDOG_LIMIT = 60000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  grid_dda_line_of_sight_core u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: wall map and register copies.
  bit          walls [gdlos_pkg::MAP_DEPTH];
  int unsigned map_w = 64, map_h = 64, tile_px = 32;
  bit          clear_q [$];
  int          errors = 0, n_casts = 0, n_blocked = 0, n_flags = 0;
  bit          quiet_rx = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit [31:0] sat_sum(bit [31:0] a, bit [31:0] b);
    bit [32:0] s;
    s = {1'b0, a} + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic bit wall_at(int cx, int cy);
    int unsigned col, row;
    if (cx < 0 || cy < 0 || tile_px == 0) return 1'b0;
    if (cx >= map_w * tile_px || cy >= map_h * tile_px) return 1'b0;
    col = cx / tile_px;
    row = cy / tile_px;
    if (col >= gdlos_pkg::MAX_MAP_WIDTH || row >= gdlos_pkg::MAX_MAP_HEIGHT) return 1'b0;
    return walls[row * gdlos_pkg::MAX_MAP_WIDTH + col];
  endfunction

  function automatic bit sight_is_clear(int ox, int oy, int tx, int ty);
    int dx, dy, cx, cy;
    longint unsigned adx, ady, sq;
    bit [31:0] dmax, stx, sty, lx, ly, walked;
    dx = tx - ox;
    dy = ty - oy;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    sq = adx * adx + ady * ady;
    dmax = 32'(int_sqrt(sq << 32));
    stx = (adx == 0) ? 32'hFFFF_FFFF : dmax / 32'(adx);
    sty = (ady == 0) ? 32'hFFFF_FFFF : dmax / 32'(ady);
    lx = (dx < 0) ? 32'd0 : stx;
    ly = (dy < 0) ? 32'd0 : sty;
    walked = 0;
    cx = ox;
    cy = oy;
    while (walked < dmax) begin
      if (lx < ly) begin
        cx += (dx < 0) ? -1 : 1;
        walked = lx;
        lx = sat_sum(lx, stx);
      end else begin
        cy += (dy < 0) ? -1 : 1;
        walked = ly;
        ly = sat_sum(ly, sty);
      end
      if (wall_at(cx, cy)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic cfg_write(logic [1:0] idx, bit [31:0] val);
    int unsigned v;
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
    v = val & 32'h7F;
    case (idx)
      gdlos_pkg::REG_MAP_WIDTH:
        map_w   = (v > gdlos_pkg::MAX_MAP_WIDTH)  ? gdlos_pkg::MAX_MAP_WIDTH  : v;
      gdlos_pkg::REG_MAP_HEIGHT:
        map_h   = (v > gdlos_pkg::MAX_MAP_HEIGHT) ? gdlos_pkg::MAX_MAP_HEIGHT : v;
      gdlos_pkg::REG_TILE_SIZE:
        tile_px = (v > gdlos_pkg::MAX_TILE_SIZE)  ? gdlos_pkg::MAX_TILE_SIZE  : v;
      default: ;
    endcase
  endtask

  // Drives one beat and updates the predictor once it is taken.
  task automatic send_beat(los_row_t r, bit may_idle);
    bit want;
    while (may_idle && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.act;
    in_tdata  <= {3'b0, r.ty, r.tx, r.oy, r.ox, r.flag, r.tile};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (r.act == ACT_FLAG) begin
      walls[r.tile] = r.flag;
      n_flags++;
    end else begin
      want = r.typed ? r.clear : sight_is_clear(r.ox, r.oy, r.tx, r.ty);
      clear_q = {clear_q, want};
      n_casts++;
    end
  endtask

  function automatic bit [11:0] near(bit [11:0] p, int span);
    int v;
    v = int'(p) + $urandom_range(2 * span) - span;
    return (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : 12'(v);
  endfunction

  function automatic los_row_t random_row();
    los_row_t r;
    r.typed = 1'b0;
    r.clear = 1'b0;
    r.act   = ($urandom_range(99) < 30) ? ACT_FLAG : ACT_CAST;
    r.flag  = ($urandom_range(99) < 60);
    r.tile  = $urandom_range(4095);
    r.ox    = $urandom_range(4095);
    r.oy    = $urandom_range(4095);
    r.tx    = $urandom_range(4095);
    r.ty    = $urandom_range(4095);
    // Most beats keep to the top-left corner so that rays meet the walls written there.
    if ($urandom_range(99) < 75) begin
      r.tile = {$urandom_range(7) == 0 ? 6'($urandom_range(63)) : 6'($urandom_range(7)),
                6'($urandom_range(9))};
      r.ox = $urandom_range(400);
      r.oy = $urandom_range(400);
    end
    if ($urandom_range(99) >= 3) begin
      r.tx = near(r.ox, 90);
      r.ty = near(r.oy, 90);
    end
    return r;
  endfunction

  los_row_t directed [] = '{
    '{ACT_CAST, 12'd0,    1'b0, 12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 1'b1},
    '{ACT_CAST, 12'd4095, 1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1},
    '{ACT_CAST, 12'd0,    1'b0, 12'd0,    12'd0,    12'd100,  12'd0,    1'b1, 1'b1},
    '{ACT_FLAG, 12'd2,    1'b1, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 1'b0},
    '{ACT_CAST, 12'd0,    1'b0, 12'd0,    12'd10,   12'd100,  12'd10,   1'b1, 1'b0},
    '{ACT_CAST, 12'd0,    1'b0, 12'd10,   12'd10,   12'd20,   12'd10,   1'b1, 1'b1},
    '{ACT_FLAG, 12'd4095, 1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, 1'b0},
    '{ACT_CAST, 12'd0,    1'b0, 12'd2000, 12'd2000, 12'd2040, 12'd2040, 1'b1, 1'b0},
    '{ACT_CAST, 12'd0,    1'b0, 12'd4095, 12'd4095, 12'd0,    12'd0,    1'b0, 1'b0},
    '{ACT_CAST, 12'd0,    1'b0, 12'd0,    12'd4095, 12'd4095, 12'd0,    1'b0, 1'b0},
    '{ACT_FLAG, 12'd2,    1'b0, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 1'b0},
    '{ACT_CAST, 12'd0,    1'b0, 12'd0,    12'd10,   12'd100,  12'd10,   1'b1, 1'b1},
    '{ACT_CAST, 12'd0,    1'b0, 12'd4095, 12'd0,    12'd0,    12'd4095, 1'b0, 1'b0},
    '{ACT_CAST, 12'd0,    1'b0, 12'd100,  12'd10,   12'd0,    12'd10,   1'b1, 1'b1},
    '{ACT_CAST, 12'd0,    1'b0, 12'd40,   12'd40,   12'd40,   12'd0,    1'b0, 1'b0}
  };

  // Result side: random stalls, checked against the oldest expectation.
  always @(posedge clk) begin
    bit want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (clear_q.size() == 0) begin
          $display("%0t: unexpected result beat, actual sight_clear=%0b", $time, out_tdata[0]);
          errors++;
        end else begin
          want = clear_q.pop_front();
          if (out_tdata[0] !== want) begin
            $display("%0t: sight_clear mismatch, expected %0b actual %0b",
                     $time, want, out_tdata[0]);
            errors++;
          end
          if (!want) n_blocked++;
        end
      end
      out_tready <= quiet_rx || ($urandom_range(99) >= 35);
    end
  end

  // Counts cycles in which no beat moves on any port.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, clear_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic wait_drained();
    while (clear_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    bit [6:0] settings [5][3] = '{
      '{7'd1,  7'd1,   7'd1},
      '{7'd0,  7'd64,  7'd32},
      '{7'd127, 7'd100, 7'd127},
      '{7'd8,  7'd12,  7'd16},
      '{7'd64, 7'd64,  7'd32}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_beat(directed[i], 1'b1);
    in_tvalid <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      if (ph < 5) begin
        cfg_write(gdlos_pkg::REG_MAP_WIDTH,
                  {$urandom_range(1) ? 25'h1FFFFFF : 25'h0, settings[ph][0]});
        cfg_write(gdlos_pkg::REG_MAP_HEIGHT, {25'($urandom), settings[ph][1]});
        cfg_write(gdlos_pkg::REG_TILE_SIZE,  {25'($urandom), settings[ph][2]});
      end else begin
        cfg_write(gdlos_pkg::REG_MAP_WIDTH,  $urandom_range(127));
        cfg_write(gdlos_pkg::REG_MAP_HEIGHT, $urandom_range(127));
        cfg_write(gdlos_pkg::REG_TILE_SIZE,  $urandom_range(127));
      end
      quiet_rx = (ph == 4);
      for (int k = 0; k < 150; k++) send_beat(random_row(), ph != 4);
      in_tvalid <= 1'b0;
    end
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Covered %0d casts (%0d blocked) and %0d wall-flag writes", n_casts, n_blocked,
             n_flags);
    $display("over six register settings, including empty and saturated maps.");
    if (errors == 0 && clear_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire
